FILE: hdl/char_lcd_bus_sequencer_defines.svh
// Assertion macros used by the checker file of the LCD bus sequencer.
`ifndef CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_BUS_SEQUENCER_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CLBS_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clbs check failed");

// A stalled item must stay valid and unchanged in the next cycle.
`define CLBS_ASSERT_HOLD(label, vld, rdy, pay) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		((vld) && !(rdy)) |=> ((vld) && $stable(pay))) \
		else $error("clbs stalled item changed");

`endif

FILE: hdl/clbs_pkg.sv
package clbs_pkg;

	localparam int CmdDataW = 24;
	localparam int StrobeDataW = 16;
	localparam int ApbAddrW = 5;
	localparam int ApbDataW = 32;
	localparam logic [5:0] InitLeadMs = 6'd50;

	localparam logic [2:0] ACT_WRITE = 3'd0;
	localparam logic [2:0] ACT_INIT = 3'd1;
	localparam logic [2:0] ACT_GOTO = 3'd2;
	localparam logic [2:0] ACT_CLEAR = 3'd3;
	localparam logic [2:0] ACT_GLYPH_BEGIN = 3'd4;
	localparam logic [2:0] ACT_GLYPH_END = 3'd5;

	localparam logic [2:0] REG_FOUR_BIT = 3'd0;
	localparam logic [2:0] REG_LINE_ONE = 3'd1;
	localparam logic [2:0] REG_LINE_TWO = 3'd2;
	localparam logic [2:0] REG_LINE_THREE = 3'd3;
	localparam logic [2:0] REG_LINE_FOUR = 3'd4;

	localparam logic [7:0] INS_FUNC_8BIT = 8'h38;
	localparam logic [7:0] INS_FUNC_4BIT = 8'h28;
	localparam logic [7:0] INS_DISPLAY_ON = 8'h0c;
	localparam logic [7:0] INS_CLEAR = 8'h01;
	localparam logic [7:0] INS_ENTRY_MODE = 8'h06;
	localparam logic [7:0] INS_HOME = 8'h02;
	localparam logic [7:0] INS_DDRAM = 8'h80;

	typedef struct packed {
		logic       four_bit_bus;
		logic [6:0] line_one_base;
		logic [6:0] line_two_base;
		logic [6:0] line_three_base;
		logic [6:0] line_four_base;
	} cfg_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data_byte;
		logic [1:0] line_select;
		logic [5:0] cell_index;
		logic [2:0] glyph_slot;
	} cmd_t;

	typedef struct packed {
		logic       reg_select;
		logic [7:0] bus_value;
		logic [5:0] lead_ms;
		logic [1:0] settle_ms;
		logic       last_strobe;
	} strobe_t;

	// Number of strobes a command expands into.
	function automatic logic [3:0] strobe_count(logic [2:0] action, logic four_bit);
		logic [3:0] n;
		case (action)
			ACT_INIT: n = four_bit ? 4'd10 : 4'd4;
			ACT_WRITE, ACT_GOTO, ACT_CLEAR, ACT_GLYPH_BEGIN, ACT_GLYPH_END:
				n = four_bit ? 4'd2 : 4'd1;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

	// Strobe number idx of a command; last_strobe is filled in by the caller.
	function automatic strobe_t make_strobe(cmd_t cmd, logic four_bit, logic [3:0] idx,
			logic [7:0] goto_byte);
		logic [2:0] bidx;
		logic [7:0] byte_v;
		logic [1:0] settle_v;
		strobe_t s;
		bidx = four_bit ? idx[3:1] : idx[2:0];
		byte_v = 8'h00;
		settle_v = 2'd0;
		s.reg_select = 1'b0;
		case (cmd.action)
			ACT_WRITE: begin
				byte_v = cmd.data_byte;
				s.reg_select = 1'b1;
			end
			ACT_INIT: begin
				if (four_bit) begin
					case (bidx)
						3'd0: byte_v = INS_HOME;
						3'd1: begin byte_v = INS_FUNC_4BIT; settle_v = 2'd1; end
						3'd2: begin byte_v = INS_DISPLAY_ON; settle_v = 2'd1; end
						3'd3: begin byte_v = INS_CLEAR; settle_v = 2'd2; end
						default: byte_v = INS_ENTRY_MODE;
					endcase
				end else begin
					case (bidx)
						3'd0: begin byte_v = INS_FUNC_8BIT; settle_v = 2'd1; end
						3'd1: begin byte_v = INS_DISPLAY_ON; settle_v = 2'd1; end
						3'd2: begin byte_v = INS_CLEAR; settle_v = 2'd2; end
						default: byte_v = INS_ENTRY_MODE;
					endcase
				end
			end
			ACT_GOTO: byte_v = goto_byte;
			ACT_CLEAR: begin
				byte_v = INS_CLEAR;
				settle_v = 2'd1;
			end
			ACT_GLYPH_BEGIN: byte_v = {2'b01, cmd.glyph_slot, 3'b000};
			ACT_GLYPH_END: byte_v = INS_DDRAM;
			default: byte_v = 8'h00;
		endcase
		s.lead_ms = (cmd.action == ACT_INIT && idx == 4'd0) ? InitLeadMs : 6'd0;
		if (four_bit) begin
			// High nibble first; the settle time belongs to the low nibble.
			s.bus_value = idx[0] ? {4'h0, byte_v[3:0]} : {4'h0, byte_v[7:4]};
			s.settle_ms = idx[0] ? settle_v : 2'd0;
		end else begin
			s.bus_value = byte_v;
			s.settle_ms = settle_v;
		end
		s.last_strobe = 1'b0;
		return s;
	endfunction

endpackage

FILE: hdl/clbs_cfg.sv
module clbs_cfg
	import clbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ApbAddrW-1:0] paddr,
	input  logic [ApbDataW-1:0] pwdata,
	output logic [ApbDataW-1:0] prdata,
	output logic                pready,
	output cfg_t                cfg
);

	cfg_t cfg_q;
	logic wr_en;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[ApbAddrW-1:2];
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.four_bit_bus <= 1'b0;
			cfg_q.line_one_base <= 7'd0;
			cfg_q.line_two_base <= 7'd64;
			cfg_q.line_three_base <= 7'd20;
			cfg_q.line_four_base <= 7'd84;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FOUR_BIT: cfg_q.four_bit_bus <= pwdata[0];
				REG_LINE_ONE: cfg_q.line_one_base <= pwdata[6:0];
				REG_LINE_TWO: cfg_q.line_two_base <= pwdata[6:0];
				REG_LINE_THREE: cfg_q.line_three_base <= pwdata[6:0];
				REG_LINE_FOUR: cfg_q.line_four_base <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_FOUR_BIT: prdata = {{(ApbDataW-1){1'b0}}, cfg_q.four_bit_bus};
			REG_LINE_ONE: prdata = {{(ApbDataW-7){1'b0}}, cfg_q.line_one_base};
			REG_LINE_TWO: prdata = {{(ApbDataW-7){1'b0}}, cfg_q.line_two_base};
			REG_LINE_THREE: prdata = {{(ApbDataW-7){1'b0}}, cfg_q.line_three_base};
			REG_LINE_FOUR: prdata = {{(ApbDataW-7){1'b0}}, cfg_q.line_four_base};
			default: prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/clbs_expand.sv
module clbs_expand
	import clbs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    cmd_valid,
	output logic    cmd_ready,
	input  cmd_t    cmd,
	output logic    st_valid,
	input  logic    st_ready,
	output strobe_t st
);

	cmd_t cmd_s1;
	logic valid_s1;
	logic [3:0] idx_q;
	logic [3:0] count;
	logic [6:0] base;
	logic [7:0] goto_byte;
	logic is_last;
	logic emit;
	logic done;
	strobe_t st_raw;

	always_comb begin
		case (cmd_s1.line_select)
			2'd0: base = cfg.line_one_base;
			2'd1: base = cfg.line_two_base;
			2'd2: base = cfg.line_three_base;
			default: base = cfg.line_four_base;
		endcase
	end

	// Set-address instruction; the sum wraps at eight bits.
	assign goto_byte = {1'b1, base} + {2'b00, cmd_s1.cell_index};

	assign count = strobe_count(cmd_s1.action, cfg.four_bit_bus);
	assign is_last = (idx_q == count - 4'd1);
	assign emit = valid_s1 && (count != 4'd0) && st_ready;
	// Unknown actions retire at once without a strobe.
	assign done = valid_s1 && ((count == 4'd0) || (emit && is_last));
	assign cmd_ready = !valid_s1 || done;

	always_comb begin
		st_raw = make_strobe(cmd_s1, cfg.four_bit_bus, idx_q, goto_byte);
		st_raw.last_strobe = is_last;
	end

	assign st = st_raw;
	assign st_valid = valid_s1 && (count != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q <= 4'd0;
		end else if (cmd_valid && cmd_ready) begin
			valid_s1 <= 1'b1;
			idx_q <= 4'd0;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
	end

endmodule

FILE: hdl/clbs_out_reg.sv
module clbs_out_reg
	import clbs_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  strobe_t in_st,
	output logic    out_valid,
	input  logic    out_ready,
	output strobe_t out_st
);

	logic valid_q;
	strobe_t st_q;

	assign in_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_st = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			st_q <= in_st;
		end
	end

endmodule

FILE: hdl/char_lcd_bus_sequencer.sv
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_tvalid / s_tready       tuser action, tdata command operands
// m_axis    out        m_tvalid / m_tready       tuser reg_select, tdata strobe, tlast
// apb       in         psel, penable, pready     five config registers at 4*i
//
// A command is held in the command register, then gives one strobe per cycle into the
// output register while it can take one: 1 to 10 strobes per command, set by strobe_count.
// Unknown actions are dropped in the cycle after acceptance without any strobe.
// A new command is taken in the cycle its last strobe moves to the output register.
// m_tready low while the output register holds a strobe holds it and the strobe counter in place.
// arst_n clears the valid flags and loads the register reset values.
module char_lcd_bus_sequencer
	import clbs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// data_byte[7:0], line_select[9:8], cell_index[15:10], glyph_slot[18:16], zero fill
	input  logic [CmdDataW-1:0]    s_tdata,
	// action[2:0]
	input  logic [2:0]             s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// bus_value[7:0], lead_ms[13:8], settle_ms[15:14]
	output logic [StrobeDataW-1:0] m_tdata,
	// reg_select[0]
	output logic                   m_tuser,
	output logic                   m_tlast,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ApbAddrW-1:0]    paddr,
	input  logic [ApbDataW-1:0]    pwdata,
	output logic [ApbDataW-1:0]    prdata,
	output logic                   pready
);

	cfg_t cfg;
	cmd_t cmd;
	strobe_t st;
	strobe_t out_st;
	logic st_valid;
	logic st_ready;

	assign cmd.action = s_tuser;
	assign cmd.data_byte = s_tdata[7:0];
	assign cmd.line_select = s_tdata[9:8];
	assign cmd.cell_index = s_tdata[15:10];
	assign cmd.glyph_slot = s_tdata[18:16];

	clbs_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	clbs_expand u_expand (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.st_valid  (st_valid),
		.st_ready  (st_ready),
		.st        (st)
	);

	clbs_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (st_valid),
		.in_ready  (st_ready),
		.in_st     (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_st    (out_st)
	);

	assign m_tdata = {out_st.settle_ms, out_st.lead_ms, out_st.bus_value};
	assign m_tuser = out_st.reg_select;
	assign m_tlast = out_st.last_strobe;

endmodule

FILE: hdl/clbs_checker.sv
`include "char_lcd_bus_sequencer_defines.svh"

module clbs_checker
	import clbs_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [StrobeDataW-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	`CLBS_ASSERT_HOLD(a_out_hold, m_tvalid, m_tready, {m_tdata, m_tuser, m_tlast})
	// Data writes never carry delays.
	`CLBS_ASSERT_IMPLY(a_data_no_wait, m_tvalid && m_tuser, m_tdata[15:8] == 8'h00)
	// The only lead delay is the init lead on an instruction strobe.
	`CLBS_ASSERT_IMPLY(a_lead_init, m_tvalid && (m_tdata[13:8] != 6'd0),
		(m_tdata[13:8] == InitLeadMs) && !m_tuser && !m_tlast)
	`CLBS_ASSERT_IMPLY(a_settle_range, m_tvalid, m_tdata[15:14] != 2'b11)

endmodule

bind char_lcd_bus_sequencer clbs_checker u_clbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
